>>> rtl/pulse_width_frame_receiver_assert.svh
// ----------------------------------------------------------------------------
// pulse_width_frame_receiver_assert.svh
// assertion macros for the pulse-width frame receiver, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef PULSE_WIDTH_FRAME_RECEIVER_ASSERT_SVH
`define PULSE_WIDTH_FRAME_RECEIVER_ASSERT_SVH

`ifndef SYNTHESIS
// checked only while out of reset
`define PWFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked during reset as well
`define PWFR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PWFR_ASSERT(lbl, prop, msg)
`define PWFR_ASSERT_RST(lbl, prop, msg)
`endif

`endif

>>> rtl/pwfr_pkg.sv
// ----------------------------------------------------------------------------
// pwfr_pkg
// types, codes and the crc helper of the pulse-width frame receiver
// ----------------------------------------------------------------------------
`default_nettype none

package pwfr_pkg;

  localparam int unsigned PREAMBLE_BYTES = 2;
  localparam int unsigned COUNT_BITS     = 16;

  localparam logic [7:0]  PREAMBLE_BYTE = 8'hAA;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'h1021;
  localparam logic [15:0] CRC_MSB       = 16'h8000;

  // configuration register indexes
  localparam logic [7:0] REG_START_THRESHOLD = 8'd0;
  localparam logic [7:0] REG_ZERO_MIN        = 8'd1;
  localparam logic [7:0] REG_ZERO_MAX        = 8'd2;
  localparam logic [7:0] REG_ONE_MIN         = 8'd3;
  localparam logic [7:0] REG_ONE_MAX         = 8'd4;
  localparam logic [7:0] REG_MAX_PAYLOAD_LEN = 8'd5;

  typedef enum logic [0:0] {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } out_kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_CRC_BAD   = 3'd1,
    ST_PREAMBLE  = 3'd2,
    ST_TOO_LONG  = 3'd3,
    ST_UNREAD    = 3'd4,
    ST_RESTART   = 3'd5
  } frame_status_t;

  typedef enum logic [7:0] {
    PH_HUNT = 8'b0000_0001,
    PH_PRE  = 8'b0000_0010,
    PH_TYPE = 8'b0000_0100,
    PH_LHI  = 8'b0000_1000,
    PH_LLO  = 8'b0001_0000,
    PH_RES  = 8'b0010_0000,
    PH_PAY  = 8'b0100_0000,
    PH_CRC  = 8'b1000_0000
  } phase_t;

  // crc-16 ccitt, msb first, one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/pulse_width_frame_receiver.sv
// ----------------------------------------------------------------------------
// pulse_width_frame_receiver
// decodes pulse-width symbols into framed bytes, checks preamble and crc
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per symbol window, tdata = high-sample count.
//   out_* : one request per payload byte (tuser = 0) or per end-of-frame
//           status (tuser = 1); tdata carries byte, type, length, status
//           and the received crc word.
//   cfg_* : register writes, taken at any time, always ready; write only
//           while no symbol is in flight.
// A symbol is accepted into the input register; its result is registered in the
// result register once that register can take it, and then shows on out_*.
// Throughput is one symbol per cycle while out_tready stays high: an input
// register feeds the combinational decode logic, a single-byte crc update and
// the phase machine, into a result register.
// When the result register is full and out_tready is low, the input register
// keeps its symbol and in_tready falls once it is occupied; nothing is lost.
// Reset clears both valid flags, puts the phase machine into hunting and
// loads the register defaults (600, 290, 600, 20, 290, 256).
// ----------------------------------------------------------------------------
`default_nettype none

`include "pulse_width_frame_receiver_assert.svh"

module pulse_width_frame_receiver
  import pwfr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // symbol input
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] symbol_high_count
  // result output
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // [7:0] out_byte, [15:8] msg_type,
                                       // [31:16] msg_length, [34:32] frame_status,
                                       // [50:35] received_crc, [55:51] zero
  output logic             out_tuser,  // [0] out_kind
  // configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  // configuration registers
  logic [15:0] start_thr_r, zero_min_r, zero_max_r, one_min_r, one_max_r, max_len_r;

  // input stage
  logic                  in_valid_r;
  logic [COUNT_BITS-1:0] in_count_r;
  logic                  adv;

  // frame state
  phase_t      phase_r, phase_nxt;
  logic [2:0]  bit_pos_r, bit_pos_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [15:0] byte_cnt_r, byte_cnt_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [15:0] length_r, length_nxt;
  logic [15:0] crc_acc_r, crc_acc_nxt;
  logic [15:0] crc_rx_r, crc_rx_nxt;

  // result stage
  logic          out_valid_r;
  out_kind_t     out_kind_r;
  logic [7:0]    out_byte_r;
  logic [7:0]    out_type_r;
  logic [15:0]   out_len_r;
  frame_status_t out_status_r;
  logic [15:0]   out_crc_r;

  // step results
  logic          emit;
  out_kind_t     res_kind;
  logic [7:0]    res_byte;
  frame_status_t res_status;
  logic [15:0]   res_crc;

  logic          is_start, is_zero, is_one;
  logic [7:0]    byte_full;
  logic [16:0]   cnt_inc;
  logic [15:0]   crc_rx_shift;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_thr_r <= 16'd600;
      zero_min_r  <= 16'd290;
      zero_max_r  <= 16'd600;
      one_min_r   <= 16'd20;
      one_max_r   <= 16'd290;
      max_len_r   <= 16'd256;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_START_THRESHOLD: start_thr_r <= cfg_data;
        REG_ZERO_MIN:        zero_min_r  <= cfg_data;
        REG_ZERO_MAX:        zero_max_r  <= cfg_data;
        REG_ONE_MIN:         one_min_r   <= cfg_data;
        REG_ONE_MAX:         one_max_r   <= cfg_data;
        REG_MAX_PAYLOAD_LEN: max_len_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // the input register drains whenever the result register can take a result
  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      in_count_r <= in_tdata[COUNT_BITS-1:0];
    end
  end

  assign is_start     = in_count_r > start_thr_r;
  assign is_zero      = (in_count_r > zero_min_r) && (in_count_r < zero_max_r);
  assign is_one       = (in_count_r > one_min_r) && (in_count_r < one_max_r);
  assign byte_full    = {shift_r[6:0], !is_zero};
  assign cnt_inc      = {1'b0, byte_cnt_r} + 17'd1;
  assign crc_rx_shift = {crc_rx_r[7:0], byte_full};

  always_comb begin
    phase_nxt    = phase_r;
    bit_pos_nxt  = bit_pos_r;
    shift_nxt    = shift_r;
    byte_cnt_nxt = byte_cnt_r;
    type_nxt     = type_r;
    length_nxt   = length_r;
    crc_acc_nxt  = crc_acc_r;
    crc_rx_nxt   = crc_rx_r;
    emit         = 1'b0;
    res_kind     = KIND_STATUS;
    res_byte     = 8'h00;
    res_status   = ST_OK;
    res_crc      = crc_rx_r;

    if (adv) begin
      if (is_start) begin
        // start tone: report a restart if a frame was open, then begin anew
        emit         = (phase_r != PH_HUNT);
        res_status   = ST_RESTART;
        phase_nxt    = PH_PRE;
        bit_pos_nxt  = 3'd0;
        shift_nxt    = 8'h00;
        byte_cnt_nxt = 16'h0000;
        type_nxt     = 8'h00;
        length_nxt   = 16'h0000;
        crc_acc_nxt  = CRC_INIT;
        crc_rx_nxt   = 16'h0000;
      end else if (!is_zero && !is_one) begin
        if (phase_r != PH_HUNT) begin
          emit        = 1'b1;
          res_status  = ST_UNREAD;
          phase_nxt   = PH_HUNT;
          bit_pos_nxt = 3'd0;
          shift_nxt   = 8'h00;
        end
      end else if (phase_r != PH_HUNT) begin
        if (bit_pos_r != 3'd7) begin
          shift_nxt   = byte_full;
          bit_pos_nxt = bit_pos_r + 3'd1;
        end else begin
          bit_pos_nxt = 3'd0;
          shift_nxt   = 8'h00;
          case (phase_r)
            PH_PRE: begin
              if (byte_full != PREAMBLE_BYTE) begin
                emit       = 1'b1;
                res_status = ST_PREAMBLE;
                phase_nxt  = PH_HUNT;
              end else if (cnt_inc >= 17'(PREAMBLE_BYTES)) begin
                byte_cnt_nxt = 16'h0000;
                phase_nxt    = PH_TYPE;
              end else begin
                byte_cnt_nxt = cnt_inc[15:0];
              end
            end
            PH_TYPE: begin
              type_nxt  = byte_full;
              phase_nxt = PH_LHI;
            end
            PH_LHI: begin
              length_nxt = {byte_full, 8'h00};
              phase_nxt  = PH_LLO;
            end
            PH_LLO: begin
              length_nxt = {length_r[15:8], byte_full};
              phase_nxt  = PH_RES;
            end
            PH_RES: begin
              if (length_r > max_len_r) begin
                emit       = 1'b1;
                res_status = ST_TOO_LONG;
                phase_nxt  = PH_HUNT;
              end else begin
                byte_cnt_nxt = 16'h0000;
                phase_nxt    = (length_r == 16'h0000) ? PH_CRC : PH_PAY;
              end
            end
            PH_PAY: begin
              crc_acc_nxt = crc_byte(crc_acc_r, byte_full);
              emit        = 1'b1;
              res_kind    = KIND_DATA;
              res_byte    = byte_full;
              res_crc     = 16'h0000;
              if (cnt_inc >= {1'b0, length_r}) begin
                byte_cnt_nxt = 16'h0000;
                phase_nxt    = PH_CRC;
              end else begin
                byte_cnt_nxt = cnt_inc[15:0];
              end
            end
            PH_CRC: begin
              crc_rx_nxt   = crc_rx_shift;
              byte_cnt_nxt = cnt_inc[15:0];
              res_crc      = crc_rx_shift;
              if (cnt_inc >= 17'd2) begin
                emit       = 1'b1;
                res_status = (crc_rx_shift == crc_acc_r) ? ST_OK : ST_CRC_BAD;
                phase_nxt  = PH_HUNT;
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT;
      bit_pos_r  <= 3'd0;
      shift_r    <= 8'h00;
      byte_cnt_r <= 16'h0000;
      type_r     <= 8'h00;
      length_r   <= 16'h0000;
      crc_acc_r  <= CRC_INIT;
      crc_rx_r   <= 16'h0000;
    end else begin
      phase_r    <= phase_nxt;
      bit_pos_r  <= bit_pos_nxt;
      shift_r    <= shift_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      type_r     <= type_nxt;
      length_r   <= length_nxt;
      crc_acc_r  <= crc_acc_nxt;
      crc_rx_r   <= crc_rx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= emit;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // type and length go out as they stood before this symbol
  always_ff @(posedge clk) begin
    if (adv) begin
      out_kind_r   <= res_kind;
      out_byte_r   <= res_byte;
      out_type_r   <= type_r;
      out_len_r    <= length_r;
      out_status_r <= res_status;
      out_crc_r    <= res_crc;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {5'b00000, out_crc_r, out_status_r, out_len_r, out_type_r, out_byte_r};

  `PWFR_ASSERT_RST(a_no_result_after_reset, !rst_n |=> !out_valid_r,
                   "result valid right after reset")
  `PWFR_ASSERT(a_data_item_clean,
               (out_valid_r && out_kind_r == KIND_DATA) |->
                 (out_status_r == ST_OK && out_crc_r == 16'h0000),
               "payload byte carries status or crc")
  `PWFR_ASSERT(a_hold_when_stalled,
               (in_valid_r && out_valid_r && !out_tready) |-> !in_tready,
               "input taken while result stage blocked")
  `PWFR_ASSERT(a_hunt_idle_bits, (phase_r == PH_HUNT) |-> (bit_pos_r == 3'd0 && shift_r == 8'h00),
               "bit assembly active while hunting")
  `PWFR_ASSERT(a_payload_count, (phase_r == PH_PAY) |-> (byte_cnt_r < length_r),
               "payload count past length")

endmodule

`default_nettype wire
